// ===== rtl/jul_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jul_pkg
// Shared constants, register indexes and the configuration bundle of the
// Julia escape-time pixel engine.
// ----------------------------------------------------------------------------
package jul_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int ITER_BITS_DEF   = 16;
    localparam int COORD_BITS_DEF  = 12;
    localparam int ZOOM_FRAC       = 16;
    localparam int DIM_W           = 13;
    localparam int ZOOM_W          = 32;
    localparam int OFFSET_W        = 32;
    localparam int CONST_W         = 28;
    localparam int LIMIT_W         = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    // Start point: signed, saturated to +-8.0
    localparam int START_W         = FRAC_BITS + 5;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_RE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_IM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_RE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_C_IM   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]           image_width;
        logic [DIM_W-1:0]           image_height;
        logic [ZOOM_W-1:0]          zoom_factor;
        logic signed [OFFSET_W-1:0] offset_real;
        logic signed [OFFSET_W-1:0] offset_imag;
        logic signed [CONST_W-1:0]  const_real;
        logic signed [CONST_W-1:0]  const_imag;
        logic [LIMIT_W-1:0]         iteration_limit;
    } cfg_t;

endpackage

// ===== rtl/jul_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jul_if
// Valid/ready channels of the pixel engine: pixels in, results out, and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface pix_if #(parameter int COORD_BITS = jul_pkg::COORD_BITS_DEF);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface res_if #(parameter int ITER_BITS = jul_pkg::ITER_BITS_DEF);
    logic                 valid;
    logic                 ready;
    logic [ITER_BITS-1:0] iteration_count;
    logic                 escaped;
    modport source (output valid, output iteration_count, output escaped, input ready);
    modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface

interface cfg_if;
    logic                            valid;
    logic                            ready;
    logic [jul_pkg::CFG_IDX_W-1:0]   index;
    logic [jul_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/jul_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jul_front
// Accepts a pixel and maps it to the start point z0 with two restoring
// dividers working side by side, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jul_front #(
    parameter int COORD_BITS = jul_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    pix_if.sink                                  pixel,
    input  jul_pkg::cfg_t                        cfg,
    input  logic                                 full,
    output logic                                 push,
    output logic signed [jul_pkg::START_W-1:0]   re0,
    output logic signed [jul_pkg::START_W-1:0]   im0
);

    localparam int DW     = ((COORD_BITS > jul_pkg::DIM_W - 1) ? COORD_BITS
                                                              : jul_pkg::DIM_W - 1) + 1;
    localparam int MW     = DW - 1;
    localparam int NW     = MW + 2;
    localparam int KSTEPS = NW + jul_pkg::ZOOM_FRAC + jul_pkg::FRAC_BITS;
    localparam int QW     = KSTEPS;
    localparam int DVW    = jul_pkg::ZOOM_W + jul_pkg::DIM_W;
    localparam int RW     = DVW + 1;
    localparam int CNTW   = $clog2(KSTEPS + 1);
    localparam int AW     = QW + 2;
    localparam int ZW     = jul_pkg::START_W;
    localparam int ZOOM_W_L = jul_pkg::ZOOM_W;
    localparam logic [QW-1:0] CAP = QW'(64'd1 << 33) + QW'(64'd1 << (jul_pkg::FRAC_BITS + 4));
    localparam logic signed [AW-1:0] LIM = AW'(64'd8 << jul_pkg::FRAC_BITS);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

    state_t            state_reg;
    logic [CNTW-1:0]   step_reg;
    logic              negx_reg, negy_reg;
    logic [NW-1:0]     nx_reg, ny_reg;
    logic [DVW-1:0]    dvx_reg, dvy_reg;
    logic [RW-1:0]     rx_reg, ry_reg;
    logic [QW-1:0]     qx_reg, qy_reg;

    logic signed [DW-1:0] dx, dy;
    logic [MW-1:0]        mx, my;
    logic [ZOOM_W_L-1:0]  zc;
    logic [jul_pkg::DIM_W-1:0] wc, hc;
    logic [RW-1:0]        rx_t, ry_t;
    logic                 gex, gey;
    logic [QW-1:0]        qcx, qcy;
    logic signed [AW-1:0] ax, ay, sx, sy;

    always_comb
    begin
        dx  = $signed(DW'(pixel.pixel_x)) - $signed(DW'(cfg.image_width >> 1));
        dy  = $signed(DW'(pixel.pixel_y)) - $signed(DW'(cfg.image_height >> 1));
        mx  = dx[DW-1] ? MW'(-dx) : MW'(dx);
        my  = dy[DW-1] ? MW'(-dy) : MW'(dy);
        // A zero register value counts as one in the divisor.
        zc  = (cfg.zoom_factor == '0) ? ZOOM_W_L'(1) : cfg.zoom_factor;
        wc  = (cfg.image_width == '0) ? jul_pkg::DIM_W'(1) : cfg.image_width;
        hc  = (cfg.image_height == '0) ? jul_pkg::DIM_W'(1) : cfg.image_height;
        rx_t = {rx_reg[RW-2:0], nx_reg[NW-1]};
        ry_t = {ry_reg[RW-2:0], ny_reg[NW-1]};
        gex  = (rx_t >= {1'b0, dvx_reg});
        gey  = (ry_t >= {1'b0, dvy_reg});
        qcx  = (qx_reg > CAP) ? CAP : qx_reg;
        qcy  = (qy_reg > CAP) ? CAP : qy_reg;
        ax   = (negx_reg ? -$signed({2'b00, qcx}) : $signed({2'b00, qcx}))
               + AW'(cfg.offset_real);
        ay   = (negy_reg ? -$signed({2'b00, qcy}) : $signed({2'b00, qcy}))
               + AW'(cfg.offset_imag);
        sx   = (ax > LIM) ? LIM : ((ax < -LIM) ? -LIM : ax);
        sy   = (ay > LIM) ? LIM : ((ay < -LIM) ? -LIM : ay);
    end

    assign pixel.ready = (state_reg == S_IDLE);
    assign push        = (state_reg == S_FIN) && !full;
    assign re0         = ZW'(sx);
    assign im0         = ZW'(sy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (pixel.valid)
                    begin
                        negx_reg  <= dx[DW-1];
                        negy_reg  <= dy[DW-1];
                        nx_reg    <= NW'({mx, 1'b0}) + NW'(mx);
                        ny_reg    <= NW'({my, 1'b0});
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    dvx_reg   <= DVW'(zc) * DVW'(wc);
                    dvy_reg   <= DVW'(zc) * DVW'(hc);
                    rx_reg    <= '0;
                    ry_reg    <= '0;
                    qx_reg    <= '0;
                    qy_reg    <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    nx_reg   <= {nx_reg[NW-2:0], 1'b0};
                    ny_reg   <= {ny_reg[NW-2:0], 1'b0};
                    rx_reg   <= gex ? rx_t - {1'b0, dvx_reg} : rx_t;
                    ry_reg   <= gey ? ry_t - {1'b0, dvy_reg} : ry_t;
                    qx_reg   <= {qx_reg[QW-2:0], gex};
                    qy_reg   <= {qy_reg[QW-2:0], gey};
                    step_reg <= step_reg + CNTW'(1);
                    if (step_reg == CNTW'(KSTEPS - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/jul_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jul_fifo
// Two-entry queue of start points between the front and the iteration core.
// ----------------------------------------------------------------------------
module jul_fifo #(
    parameter int WIDTH = 2 * jul_pkg::START_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/jul_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jul_core
// Iterates z = z*z + c on one start point at a time (multiply, add, square,
// check), and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module jul_core #(
    parameter int ITER_BITS = jul_pkg::ITER_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  jul_pkg::cfg_t                        cfg,
    input  logic                                 empty,
    input  logic signed [jul_pkg::START_W-1:0]   re0,
    input  logic signed [jul_pkg::START_W-1:0]   im0,
    output logic                                 pop,
    res_if.source                                result
);

    localparam int F  = jul_pkg::FRAC_BITS;
    localparam int SW = F + 9;
    localparam int PW = 2 * SW;
    localparam int LW = jul_pkg::LIMIT_W;
    localparam logic [PW:0] BOUND = (PW + 1)'(64'd16 << F);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_SQ, S_CHK, S_DONE} state_t;

    state_t              state_reg;
    logic signed [SW-1:0] re_reg, im_reg;
    logic [PW-1:0]       prr_reg, pii_reg, pri_reg, s1_reg, s2_reg;
    logic                neg_reg;
    logic [LW-1:0]       cnt_reg;
    logic                esc_reg;
    logic                out_valid_reg;
    logic [ITER_BITS-1:0] out_count_reg;
    logic                out_esc_reg;

    logic [SW-1:0]       mre, mim;
    logic signed [PW:0]  nr_w, ni_w;
    logic [PW-1:0]       ni_mag;
    logic [PW:0]         m2;
    logic [LW-1:0]       cnt_inc;
    logic                out_load;

    always_comb
    begin
        mre     = re_reg[SW-1] ? SW'(-re_reg) : SW'(re_reg);
        mim     = im_reg[SW-1] ? SW'(-im_reg) : SW'(im_reg);
        nr_w    = $signed({1'b0, prr_reg >> F}) - $signed({1'b0, pii_reg >> F})
                  + (PW + 1)'(cfg.const_real);
        ni_mag  = pri_reg >> (F - 1);
        ni_w    = (neg_reg ? -$signed({1'b0, ni_mag}) : $signed({1'b0, ni_mag}))
                  + (PW + 1)'(cfg.const_imag);
        m2      = (PW + 1)'(s1_reg >> F) + (PW + 1)'(s2_reg >> F);
        cnt_inc = cnt_reg + LW'(1);
    end

    // The result register takes a new transaction once the old one has left.
    assign out_load               = (state_reg == S_DONE) && (!out_valid_reg || result.ready);
    assign pop                    = (state_reg == S_IDLE) && !empty;
    assign result.valid           = out_valid_reg;
    assign result.iteration_count = out_count_reg;
    assign result.escaped         = out_esc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        re_reg  <= SW'(re0);
                        im_reg  <= SW'(im0);
                        cnt_reg <= '0;
                        esc_reg <= 1'b0;
                        // A zero limit reports no iterations and no escape.
                        state_reg <= (cfg.iteration_limit == '0) ? S_DONE : S_MUL;
                    end
                end
                S_MUL:
                begin
                    prr_reg   <= mre * mre;
                    pii_reg   <= mim * mim;
                    pri_reg   <= mre * mim;
                    neg_reg   <= re_reg[SW-1] ^ im_reg[SW-1];
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    re_reg    <= SW'(nr_w);
                    im_reg    <= SW'(ni_w);
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    s1_reg    <= mre * mre;
                    s2_reg    <= mim * mim;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (m2 > BOUND)
                    begin
                        esc_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_inc;
                        state_reg <= (cnt_inc == cfg.iteration_limit) ? S_DONE : S_MUL;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_count_reg <= ITER_BITS'(cnt_reg);
                        out_esc_reg   <= esc_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/julia_escape_time_pixel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_top
// Julia-set escape-time engine: maps a pixel to z0 and counts iterations of
// z = z*z + c until |z|^2 exceeds 16 or the iteration limit is reached.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  pixel     in         pixel_x, pixel_y
//  result    out        iteration_count, escaped
//  cfg       in         index, data (register write, always ready)
//
//  The front takes each pixel through accept, divisor product, one quotient bit
//  per cycle and hand-off; the core takes each iteration through multiply, add,
//  square and check while the front works on the next pixel. The front stalls
//  while the two-entry queue is full, the core while its result register holds
//  a waiting transaction. Reset restores register defaults.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_top #(
    parameter int COORD_BITS = jul_pkg::COORD_BITS_DEF,
    parameter int ITER_BITS  = jul_pkg::ITER_BITS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    pix_if.sink    pixel,
    res_if.source  result,
    cfg_if.sink    cfg
);

    localparam int ZW = jul_pkg::START_W;

    jul_pkg::cfg_t        cfg_reg;
    logic                 push, pop, full, empty;
    logic signed [ZW-1:0] f_re0, f_im0;
    logic [2*ZW-1:0]      q_dout;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width     <= jul_pkg::DIM_W'(640);
            cfg_reg.image_height    <= jul_pkg::DIM_W'(480);
            cfg_reg.zoom_factor     <= jul_pkg::ZOOM_W'(65536);
            cfg_reg.offset_real     <= '0;
            cfg_reg.offset_imag     <= '0;
            cfg_reg.const_real      <= '0;
            cfg_reg.const_imag      <= '0;
            cfg_reg.iteration_limit <= jul_pkg::LIMIT_W'(255);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                jul_pkg::REG_WIDTH:  cfg_reg.image_width     <= cfg.data[jul_pkg::DIM_W-1:0];
                jul_pkg::REG_HEIGHT: cfg_reg.image_height    <= cfg.data[jul_pkg::DIM_W-1:0];
                jul_pkg::REG_ZOOM:   cfg_reg.zoom_factor     <= cfg.data;
                jul_pkg::REG_OFF_RE: cfg_reg.offset_real     <= cfg.data;
                jul_pkg::REG_OFF_IM: cfg_reg.offset_imag     <= cfg.data;
                jul_pkg::REG_C_RE:   cfg_reg.const_real      <= cfg.data[jul_pkg::CONST_W-1:0];
                jul_pkg::REG_C_IM:   cfg_reg.const_imag      <= cfg.data[jul_pkg::CONST_W-1:0];
                jul_pkg::REG_LIMIT:  cfg_reg.iteration_limit <= cfg.data[jul_pkg::LIMIT_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    jul_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel),
        .cfg   (cfg_reg),
        .full  (full),
        .push  (push),
        .re0   (f_re0),
        .im0   (f_im0)
    );

    jul_fifo #(.WIDTH(2 * ZW)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   ({f_re0, f_im0}),
        .pop   (pop),
        .dout  (q_dout),
        .full  (full),
        .empty (empty)
    );

    jul_core #(.ITER_BITS(ITER_BITS)) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .empty  (empty),
        .re0    ($signed(q_dout[2*ZW-1:ZW])),
        .im0    ($signed(q_dout[ZW-1:0])),
        .pop    (pop),
        .result (result)
    );

`ifndef ASSERT_OFF
    // The queue never takes a start point while it is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("start-point queue overflow");

    // The core never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("start-point queue underflow");

    // A pixel that did not escape ran the full iteration limit.
    a_full_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) && !result.escaped |->
            result.iteration_count == ITER_BITS'(cfg_reg.iteration_limit))
        else $error("non-escaping pixel stopped early");
`endif

endmodule

// ===== dv/tb_julia_escape_time_pixel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_julia_escape_time_pixel_top
// Self-checking bench for the Julia escape-time pixel engine. A table of
// directed pixels runs first, followed by configuration corners and randomly
// configured phases. Each result is checked against a table entry or a
// cycle-free model of the start-point mapping and the z = z*z + c iteration.
// Both channels stall at random, and the result side once for a long stretch.
// ----------------------------------------------------------------------------
module tb_julia_escape_time_pixel_top;

    localparam int  DRAIN     = 16;
    localparam int  MAX_CYCLE = 5000000;
    localparam int  HOLD_OFF  = 3000;
    localparam logic [63:0] ESC_BOUND = 64'd16 << jul_pkg::FRAC_BITS;

    typedef struct {
        logic [15:0] count;
        logic        escaped;
    } pix_result_t;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        bit          known;
        logic [15:0] count;
        logic        escaped;
    } pix_row_t;

    logic clk;
    logic rst_n;
    int   fail_cnt;
    int   accepted_pix;
    int   cycle_cnt;
    int   ready_low;
    int   ready_high;
    bit   pressure_done;

    // Register copies that the predictor works from.
    logic [jul_pkg::DIM_W-1:0]           img_w;
    logic [jul_pkg::DIM_W-1:0]           img_h;
    logic [jul_pkg::ZOOM_W-1:0]          zoom;
    logic signed [jul_pkg::OFFSET_W-1:0] off_re;
    logic signed [jul_pkg::OFFSET_W-1:0] off_im;
    logic signed [jul_pkg::CONST_W-1:0]  c_re;
    logic signed [jul_pkg::CONST_W-1:0]  c_im;
    logic [jul_pkg::LIMIT_W-1:0]         iter_lim;

    pix_result_t escape_q[$];

    pix_if pix_ch();
    res_if res_ch();
    cfg_if cfg_ch();

    julia_escape_time_pixel_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // trunc(a*b / 2^sh) with the magnitude saturated at 2^62.
    function automatic longint mul_trunc(longint a, longint b, int sh);
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] p;
        longint       r;
        ua = 128'(a < 0 ? -a : a);
        ub = 128'(b < 0 ? -b : b);
        p = (ua * ub) >> sh;
        if (p > (128'(1) << 62))
            p = 128'(1) << 62;
        r = longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint start_coord(longint delta, int mult,
                                           logic [jul_pkg::DIM_W-1:0] size, longint off);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] cap;
        longint       v;
        longint       lim8;
        cap  = (128'(1) << 33) + (128'(1) << (jul_pkg::FRAC_BITS + 4));
        lim8 = longint'(8) << jul_pkg::FRAC_BITS;
        num  = (128'(mult) * 128'(delta < 0 ? -delta : delta)) << (16 + jul_pkg::FRAC_BITS);
        den  = 128'(zoom == 0 ? 32'd1 : zoom) * 128'(size == 0 ? 13'd1 : size);
        q    = num / den;
        if (q > cap)
            q = cap;
        v = (delta < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
        v = v + off;
        if (v > lim8)
            v = lim8;
        if (v < -lim8)
            v = -lim8;
        return v;
    endfunction

    function automatic pix_result_t predict_escape(logic [11:0] x, logic [11:0] y);
        pix_result_t       res;
        longint            re;
        longint            im;
        longint            nr;
        longint            ni;
        longint unsigned   m2;
        int unsigned       n;
        re = start_coord(longint'(x) - longint'(img_w >> 1), 3, img_w, longint'(off_re));
        im = start_coord(longint'(y) - longint'(img_h >> 1), 2, img_h, longint'(off_im));
        n = 0;
        res.escaped = 1'b0;
        while (n < iter_lim)
        begin
            nr = mul_trunc(re, re, jul_pkg::FRAC_BITS) - mul_trunc(im, im, jul_pkg::FRAC_BITS)
                 + longint'(c_re);
            ni = mul_trunc(re, im, jul_pkg::FRAC_BITS - 1) + longint'(c_im);
            m2 = longint'(mul_trunc(nr, nr, jul_pkg::FRAC_BITS))
                 + longint'(mul_trunc(ni, ni, jul_pkg::FRAC_BITS));
            re = nr;
            im = ni;
            if (m2 > ESC_BOUND)
            begin
                res.escaped = 1'b1;
                break;
            end
            n++;
        end
        res.count = n[15:0];
        return res;
    endfunction

    task automatic cfg_write(logic [jul_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            jul_pkg::REG_WIDTH:  img_w    = data[jul_pkg::DIM_W-1:0];
            jul_pkg::REG_HEIGHT: img_h    = data[jul_pkg::DIM_W-1:0];
            jul_pkg::REG_ZOOM:   zoom     = data;
            jul_pkg::REG_OFF_RE: off_re   = data;
            jul_pkg::REG_OFF_IM: off_im   = data;
            jul_pkg::REG_C_RE:   c_re     = data[jul_pkg::CONST_W-1:0];
            jul_pkg::REG_C_IM:   c_im     = data[jul_pkg::CONST_W-1:0];
            jul_pkg::REG_LIMIT:  iter_lim = data[jul_pkg::LIMIT_W-1:0];
            default:             ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_view(logic [31:0] w, logic [31:0] h, logic [31:0] z,
                            logic [31:0] ore, logic [31:0] oim,
                            logic [31:0] cr, logic [31:0] ci, logic [31:0] lim);
        cfg_write(jul_pkg::REG_WIDTH, w);
        cfg_write(jul_pkg::REG_HEIGHT, h);
        cfg_write(jul_pkg::REG_ZOOM, z);
        cfg_write(jul_pkg::REG_OFF_RE, ore);
        cfg_write(jul_pkg::REG_OFF_IM, oim);
        cfg_write(jul_pkg::REG_C_RE, cr);
        cfg_write(jul_pkg::REG_C_IM, ci);
        cfg_write(jul_pkg::REG_LIMIT, lim);
    endtask

    // The valid line stays high across back-to-back transactions.
    task automatic send_pixel(logic [11:0] x, logic [11:0] y, bit known,
                              pix_result_t known_res);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid   <= 1'b1;
        pix_ch.pixel_x <= x;
        pix_ch.pixel_y <= y;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        escape_q.push_back(known ? known_res : predict_escape(x, y));
        accepted_pix++;
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        wait (escape_q.size() == 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic send_random(int n_items, bit full_range);
        pix_result_t none;
        logic [11:0] x;
        logic [11:0] y;
        none = '{count: '0, escaped: 1'b0};
        repeat (n_items)
        begin
            if (full_range || $urandom_range(0, 9) == 0)
            begin
                x = 12'($urandom);
                y = 12'($urandom);
            end
            else
            begin
                x = 12'($urandom_range(0, img_w == 0 ? 0 : img_w - 1));
                y = 12'($urandom_range(0, img_h == 0 ? 0 : img_h - 1));
            end
            send_pixel(x, y, 1'b0, none);
        end
    endtask

    function automatic logic [31:0] rand_dim();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd8191;
            2:       return 32'($urandom_range(1, 4096));
            default: return 32'($urandom_range(1, 96));
        endcase
    endfunction

    function automatic logic [31:0] rand_fix(int lo_mag);
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return 32'(int'($urandom_range(0, 2 * lo_mag)) - lo_mag);
    endfunction

    // Result side: random stalls plus one long hold-off once traffic is flowing.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            ready_low  = 0;
            ready_high = 0;
        end
        else if (ready_low > 0)
        begin
            res_ch.ready <= 1'b0;
            ready_low--;
        end
        else if (ready_high > 0)
        begin
            res_ch.ready <= 1'b1;
            ready_high--;
        end
        else
        begin
            res_ch.ready <= 1'b0;
            if (!pressure_done && accepted_pix >= 60)
            begin
                pressure_done = 1'b1;
                ready_low = HOLD_OFF;
            end
            else
            begin
                ready_low  = pick_gap();
                ready_high = $urandom_range(1, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (res_ch.valid && res_ch.ready)
        begin
            if (escape_q.size() == 0)
            begin
                $error("result with no pixel outstanding: count %0d escaped %0b",
                       res_ch.iteration_count, res_ch.escaped);
                fail_cnt++;
            end
            else
            begin
                pix_result_t exp_res;
                exp_res = escape_q.pop_front();
                if (res_ch.iteration_count !== exp_res.count)
                begin
                    $error("iteration_count: expected %0d, actual %0d",
                           exp_res.count, res_ch.iteration_count);
                    fail_cnt++;
                end
                if (res_ch.escaped !== exp_res.escaped)
                begin
                    $error("escaped: expected %0b, actual %0b",
                           exp_res.escaped, res_ch.escaped);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLE)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        pix_row_t    rows[$];
        pix_result_t tmp;
        rst_n          = 1'b0;
        fail_cnt       = 0;
        accepted_pix   = 0;
        cycle_cnt      = 0;
        pressure_done  = 1'b0;
        pix_ch.valid   = 1'b0;
        pix_ch.pixel_x = '0;
        pix_ch.pixel_y = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = jul_pkg::REG_WIDTH;
        cfg_ch.data    = '0;
        img_w    = 13'd640;
        img_h    = 13'd480;
        zoom     = 32'd65536;
        off_re   = '0;
        off_im   = '0;
        c_re     = '0;
        c_im     = '0;
        iter_lim = 16'd255;

        // Directed pixels under the reset view: the center never moves with c = 0,
        // and the far corner saturates and escapes on the first step.
        rows = '{
            '{12'd320,  12'd240,  1'b1, 16'd255, 1'b0},
            '{12'd4095, 12'd4095, 1'b1, 16'd0,   1'b1},
            '{12'd0,    12'd0,    1'b0, 16'd0,   1'b0},
            '{12'd4095, 12'd0,    1'b0, 16'd0,   1'b0},
            '{12'd0,    12'd4095, 1'b0, 16'd0,   1'b0},
            '{12'd319,  12'd239,  1'b0, 16'd0,   1'b0},
            '{12'd321,  12'd241,  1'b0, 16'd0,   1'b0},
            '{12'd400,  12'd300,  1'b0, 16'd0,   1'b0},
            '{12'd2730, 12'd1365, 1'b0, 16'd0,   1'b0},
            '{12'd1,    12'd2048, 1'b0, 16'd0,   1'b0},
            '{12'd639,  12'd479,  1'b0, 16'd0,   1'b0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            tmp = '{count: rows[i].count, escaped: rows[i].escaped};
            send_pixel(rows[i].x, rows[i].y, rows[i].known, tmp);
        end
        wait_idle();

        // A zero iteration limit and zero divisors.
        set_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        tmp = '{count: 16'd0, escaped: 1'b0};
        send_pixel(12'd0, 12'd0, 1'b1, tmp);
        send_pixel(12'd4095, 12'd4095, 1'b1, tmp);
        wait_idle();
        cfg_write(jul_pkg::REG_LIMIT, 32'd1);
        send_random(3, 1'b1);
        wait_idle();

        // Register extremes on the other side.
        set_view(32'd4096, 32'd4096, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h07FF_FFFF, 32'h0800_0000, 32'd20);
        send_random(3, 1'b1);
        wait_idle();
        set_view(32'd8191, 32'd1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0800_0000, 32'h07FF_FFFF, 32'd20);
        send_random(3, 1'b1);
        wait_idle();

        // The largest limit with a fixed point at the origin.
        set_view(32'd640, 32'd480, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65535);
        tmp = '{count: 16'd65535, escaped: 1'b0};
        send_pixel(12'd320, 12'd240, 1'b1, tmp);
        wait_idle();

        // A classic connected Julia set on a small image.
        set_view(32'd64, 32'd48, 32'd65536, 32'd0, 32'd0,
                 32'(-13421773), 32'd2617245, 32'd64);
        send_random(60, 1'b0);
        wait_idle();

        repeat (14)
        begin
            set_view(rand_dim(), rand_dim(),
                     ($urandom_range(0, 7) == 0) ? $urandom
                                                 : 32'($urandom_range(16384, 262144)),
                     rand_fix(1 << 25), rand_fix(1 << 25),
                     rand_fix(1 << 24), rand_fix(1 << 24),
                     ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 300))
                                                 : 32'($urandom_range(1, 48)));
            send_random(40, 1'b0);
            wait_idle();
        end

        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/jul_pkg.sv
rtl/jul_if.sv
rtl/jul_front.sv
rtl/jul_fifo.sv
rtl/jul_core.sv
rtl/julia_escape_time_pixel_top.sv
dv/tb_julia_escape_time_pixel_top.sv
